// File: rtl/uds_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package uds_pkg;

  // Byte class boundaries
  localparam logic [7:0] CONT_BASE  = 8'h80;
  localparam logic [7:0] LEAD2_BASE = 8'hC0;
  localparam logic [7:0] LEAD3_BASE = 8'hE0;
  localparam logic [7:0] LEAD4_BASE = 8'hF0;
  localparam logic [7:0] LEAD_LIMIT = 8'hF5;
  localparam logic [5:0] CONT_MASK  = 6'h3F;

  // One input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_t;

  // One result transaction
  typedef struct packed {
    logic [20:0] value;
    logic        invalid;
    logic        run_end;
  } out_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HELD,
    ST_TAIL
  } state_e;

  // Result source select
  typedef enum logic [2:0] {
    SRC_IN,
    SRC_PARTIAL,
    SRC_LEAD,
    SRC_HELD,
    SRC_BYTE
  } src_e;

  // Controller to datapath commands
  typedef struct packed {
    logic push;
    src_e src;
    logic last;
    logic open_in;
    logic open_byte;
    logic store_in;
    logic latch_in;
    logic close;
    logic idx_clr;
    logic idx_inc;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic seq_open;
    logic in_is_cont;
    logic in_starts;
    logic in_eob;
    logic complete;
    logic len_ok;
    logic held_zero;
    logic held_last;
    logic byte_starts;
  } status_t;

endpackage

// File: rtl/uds_datapath.sv
// Datapath of the UTF-8 stream decoder: sequence state, held bytes, result register.
`timescale 1ns / 1ps

module uds_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  uds_pkg::in_t     in_data_i,
  input  uds_pkg::cmd_t    cmd_i,
  output uds_pkg::status_t status_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output uds_pkg::out_t    out_data_o
);

  logic [7:0]  lead_q, lead_d;
  logic [2:0]  exp_q, exp_d;
  logic [1:0]  hc_q, hc_d;
  logic [20:0] partial_q, partial_d;
  logic [7:0]  held_q [3];
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  byte_q;
  logic        eob_q;
  logic        out_valid_q, out_valid_d;
  uds_pkg::out_t out_q, out_d;

  logic [7:0]  in_b;
  logic [20:0] new_partial;
  logic [2:0]  need_len;
  logic [7:0]  open_b;
  logic [2:0]  open_len;
  logic [20:0] open_bits;

  function automatic logic is_lead(input logic [7:0] b);
    is_lead = (b >= uds_pkg::LEAD2_BASE) && (b < uds_pkg::LEAD_LIMIT);
  endfunction

  assign in_b = in_data_i.data_byte;

  // Gather the next six payload bits
  assign new_partial = {partial_q[14:0], in_b[5:0] & uds_pkg::CONT_MASK};

  // Shortest length that encodes the gathered value
  always_comb begin
    if (new_partial <= 21'h00007F) begin
      need_len = 3'd1;
    end else if (new_partial <= 21'h0007FF) begin
      need_len = 3'd2;
    end else if (new_partial <= 21'h00FFFF) begin
      need_len = 3'd3;
    end else begin
      need_len = 3'd4;
    end
  end

  // Decode the lead byte that opens a sequence
  assign open_b = cmd_i.open_byte ? byte_q : in_b;
  always_comb begin
    if (open_b < uds_pkg::LEAD3_BASE) begin
      open_len  = 3'd2;
      open_bits = {16'd0, open_b[4:0]};
    end else if (open_b < uds_pkg::LEAD4_BASE) begin
      open_len  = 3'd3;
      open_bits = {17'd0, open_b[3:0]};
    end else begin
      open_len  = 3'd4;
      open_bits = {18'd0, open_b[2:0]};
    end
  end

  // Report status
  always_comb begin
    status_o.out_free    = !out_valid_q || !out_stall_i;
    status_o.seq_open    = (exp_q != 3'd0);
    status_o.in_is_cont  = (in_b[7:6] == uds_pkg::CONT_BASE[7:6]);
    status_o.in_starts   = is_lead(in_b) && !in_data_i.end_of_buffer;
    status_o.in_eob      = in_data_i.end_of_buffer;
    status_o.complete    = ({1'b0, hc_q} + 3'd2) >= exp_q;
    status_o.len_ok      = (need_len == exp_q);
    status_o.held_zero   = (hc_q == 2'd0);
    status_o.held_last   = ({1'b0, idx_q} + 3'd1) == {1'b0, hc_q};
    status_o.byte_starts = is_lead(byte_q) && !eob_q;
  end

  // Sequence state next values
  always_comb begin
    lead_d    = lead_q;
    exp_d     = exp_q;
    hc_d      = hc_q;
    partial_d = partial_q;
    if (cmd_i.close) begin
      lead_d    = 8'd0;
      exp_d     = 3'd0;
      hc_d      = 2'd0;
      partial_d = 21'd0;
    end else if (cmd_i.open_in || cmd_i.open_byte) begin
      lead_d    = open_b;
      exp_d     = open_len;
      hc_d      = 2'd0;
      partial_d = open_bits;
    end else if (cmd_i.store_in) begin
      hc_d      = hc_q + 2'd1;
      partial_d = new_partial;
    end
  end

  // Replay index
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = 2'd0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 2'd1;
    end
  end

  // Select the result to load
  always_comb begin
    out_d.run_end = cmd_i.last;
    case (cmd_i.src)
      uds_pkg::SRC_IN: begin
        out_d.value   = {13'd0, in_b};
        out_d.invalid = in_b[7];
      end
      uds_pkg::SRC_PARTIAL: begin
        out_d.value   = new_partial;
        out_d.invalid = 1'b0;
      end
      uds_pkg::SRC_LEAD: begin
        out_d.value   = {13'd0, lead_q};
        out_d.invalid = 1'b1;
      end
      uds_pkg::SRC_HELD: begin
        out_d.value   = {13'd0, held_q[idx_q]};
        out_d.invalid = 1'b1;
      end
      uds_pkg::SRC_BYTE: begin
        out_d.value   = {13'd0, byte_q};
        out_d.invalid = byte_q[7];
      end
      default: begin
        out_d.value   = {13'd0, byte_q};
        out_d.invalid = 1'b1;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q       <= 3'd0;
      hc_q        <= 2'd0;
      idx_q       <= 2'd0;
      lead_q      <= 8'd0;
      partial_q   <= 21'd0;
      out_valid_q <= 1'b0;
    end else begin
      exp_q       <= exp_d;
      hc_q        <= hc_d;
      idx_q       <= idx_d;
      lead_q      <= lead_d;
      partial_q   <= partial_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_in) begin
      held_q[hc_q] <= in_b;
    end
    if (cmd_i.latch_in) begin
      byte_q <= in_b;
      eob_q  <= in_data_i.end_of_buffer;
    end
    if (cmd_i.push) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/uds_controller.sv
// Controller of the UTF-8 stream decoder: accepts bytes and sequences error replays.
`timescale 1ns / 1ps

module uds_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  uds_pkg::status_t status_i,
  output uds_pkg::cmd_t    cmd_o
);

  uds_pkg::state_e state_q, state_d;
  logic tail_q, tail_d;
  logic tail_push_q, tail_push_d;
  logic idle;
  logic accept;

  assign idle       = (state_q == uds_pkg::ST_IDLE);
  assign in_stall_o = !(idle && status_i.out_free);
  assign accept     = idle && status_i.out_free && in_valid_i;

  // Next state and replay tail flags
  always_comb begin
    state_d     = state_q;
    tail_d      = tail_q;
    tail_push_d = tail_push_q;
    case (state_q)
      uds_pkg::ST_IDLE: begin
        if (accept && status_i.seq_open) begin
          if (!status_i.in_is_cont) begin
            tail_d      = 1'b1;
            tail_push_d = !status_i.in_starts;
            state_d     = status_i.held_zero ? uds_pkg::ST_TAIL : uds_pkg::ST_HELD;
          end else if (status_i.complete) begin
            if (!status_i.len_ok) begin
              tail_d      = 1'b1;
              tail_push_d = 1'b1;
              state_d     = status_i.held_zero ? uds_pkg::ST_TAIL : uds_pkg::ST_HELD;
            end
          end else if (status_i.in_eob) begin
            tail_d      = 1'b0;
            tail_push_d = 1'b0;
            state_d     = uds_pkg::ST_HELD;
          end
        end
      end
      uds_pkg::ST_HELD: begin
        if (status_i.out_free && status_i.held_last) begin
          state_d = tail_q ? uds_pkg::ST_TAIL : uds_pkg::ST_IDLE;
        end
      end
      uds_pkg::ST_TAIL: begin
        if (status_i.byte_starts || status_i.out_free) begin
          state_d = uds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = uds_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.src = uds_pkg::SRC_IN;
    case (state_q)
      uds_pkg::ST_IDLE: begin
        if (accept) begin
          if (!status_i.seq_open) begin
            // Plain byte or a new lead
            if (status_i.in_starts) begin
              cmd_o.open_in = 1'b1;
            end else begin
              cmd_o.push = 1'b1;
              cmd_o.src  = uds_pkg::SRC_IN;
              cmd_o.last = 1'b1;
            end
          end else if (!status_i.in_is_cont) begin
            // Broken sequence: replay lead and held bytes, then decode this byte again
            cmd_o.push     = 1'b1;
            cmd_o.src      = uds_pkg::SRC_LEAD;
            cmd_o.last     = status_i.held_zero && status_i.in_starts;
            cmd_o.latch_in = 1'b1;
            cmd_o.idx_clr  = 1'b1;
            cmd_o.close    = status_i.held_zero;
          end else if (status_i.complete) begin
            if (status_i.len_ok) begin
              cmd_o.push  = 1'b1;
              cmd_o.src   = uds_pkg::SRC_PARTIAL;
              cmd_o.last  = 1'b1;
              cmd_o.close = 1'b1;
            end else begin
              // Overlong: replay lead, held bytes, then this byte
              cmd_o.push     = 1'b1;
              cmd_o.src      = uds_pkg::SRC_LEAD;
              cmd_o.latch_in = 1'b1;
              cmd_o.idx_clr  = 1'b1;
              cmd_o.close    = status_i.held_zero;
            end
          end else begin
            // Hold the continuation; on truncation replay everything
            cmd_o.store_in = 1'b1;
            if (status_i.in_eob) begin
              cmd_o.push    = 1'b1;
              cmd_o.src     = uds_pkg::SRC_LEAD;
              cmd_o.idx_clr = 1'b1;
            end
          end
        end
      end
      uds_pkg::ST_HELD: begin
        if (status_i.out_free) begin
          cmd_o.push    = 1'b1;
          cmd_o.src     = uds_pkg::SRC_HELD;
          cmd_o.last    = status_i.held_last && !tail_push_q;
          cmd_o.idx_inc = 1'b1;
          cmd_o.close   = status_i.held_last;
        end
      end
      uds_pkg::ST_TAIL: begin
        if (status_i.byte_starts) begin
          cmd_o.open_byte = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.src  = uds_pkg::SRC_BYTE;
          cmd_o.last = 1'b1;
        end
      end
      default: begin
        cmd_o.push = 1'b0;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uds_pkg::ST_IDLE;
      tail_q      <= 1'b0;
      tail_push_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tail_q      <= tail_d;
      tail_push_q <= tail_push_d;
    end
  end

endmodule

// File: rtl/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder: controller plus datapath.
`timescale 1ns / 1ps

// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o  | in_data_i  (data_byte, end_of_buffer)
// out     | output    | out_valid_o / out_stall_i| out_data_o (value, invalid, run_end)
//
// A byte that decodes cleanly or opens or extends a sequence causes no replay.
// A broken or overlong sequence replays the lead, each held byte, then the byte that
// ended it unless that byte opens a new sequence, one result per cycle into the output
// register while the output is not stalled. Truncation at the end of the buffer
// replays the lead and each held byte, the final byte included.
// Reset clears the sequence state; no sequence is open after reset. Input is stalled
// while a replay runs or while the output register is full and stalled.

module utf8_stream_decoder_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  uds_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output uds_pkg::out_t out_data_o
);

  uds_pkg::cmd_t    cmd;
  uds_pkg::status_t status;

  uds_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  uds_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
